// ----- design/region_mean_and_range_test_macros.svh -----
// ----------------------------------------------------------------------------
// Region mean and range test - assertion macros
// Concurrent checks, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef REGION_MEAN_AND_RANGE_TEST_MACROS_SVH
`define REGION_MEAN_AND_RANGE_TEST_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define RMR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the following cycle
`define RMR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RMR_ASSERT_IMP(label, ante, cons, msg)
`define RMR_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ----- design/rmr_pkg.sv -----
// ----------------------------------------------------------------------------
// Region mean and range test - shared package
// Controller states, command bundle and fixed widths.
// ----------------------------------------------------------------------------
package rmr_pkg;

	localparam int PIX_W   = 8;
	localparam int QUO_W   = 8;   // mean always fits in a pixel
	localparam int STEP_W  = 3;   // counts QUO_W divide steps
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;  // 18 bits of fields, padded to bytes

	localparam logic [PIX_W-1:0]  PIX_MAX   = 8'hFF;
	localparam logic [STEP_W-1:0] STEP_LAST = 3'd7;

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_DIVIDE,
		ST_DONE
	} rmr_state_t;

	typedef struct packed {
		logic accept;   // take one pixel into the running statistics
		logic last;     // the pixel closes the region: arm the divider
		logic step;     // one restoring divide step
		logic finish;   // load the result register and clear the region
	} rmr_cmd_t;

endpackage

// ----- design/rmr_datapath.sv -----
// ----------------------------------------------------------------------------
// Region mean and range test - datapath
// Running sum, count, min and max; bit-serial restoring divider; result reg.
// ----------------------------------------------------------------------------
module rmr_datapath import rmr_pkg::*; #(
	parameter int MAX_PIXELS = 262144
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rmr_cmd_t               cmd,
	input  logic [PIX_W-1:0]       pixel,
	input  logic                   cfg_we,
	input  logic [PIX_W-1:0]       cfg_wdata,
	output logic [OUT_TDATA_W-1:0] result
);

	localparam int CNT_W = $clog2(MAX_PIXELS + 1);
	localparam int SUM_W = CNT_W + PIX_W;
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_PIXELS);

	logic [PIX_W-1:0] thresh_q;
	logic [SUM_W-1:0] sum_q, sum_nxt;
	logic [CNT_W-1:0] cnt_q, cnt_nxt;
	logic [PIX_W-1:0] min_q, max_q;
	logic             sat_q;
	logic             room;

	logic [SUM_W-1:0] rem_q, dvs_q;
	logic [QUO_W-1:0] quo_q;
	logic             ge;
	logic [PIX_W-1:0] range_w;

	assign room    = cnt_q != CNT_LIMIT;
	assign sum_nxt = room ? sum_q + SUM_W'(pixel) : sum_q;
	assign cnt_nxt = room ? cnt_q + CNT_W'(1) : cnt_q;

	assign ge      = rem_q >= dvs_q;
	// at least one pixel seen, so max >= min
	assign range_w = max_q - min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= '0;
		end else if (cfg_we) begin
			thresh_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			min_q <= PIX_MAX;
			max_q <= '0;
			sat_q <= 1'b0;
		end else if (cmd.finish) begin
			sum_q <= '0;
			cnt_q <= '0;
			min_q <= PIX_MAX;
			max_q <= '0;
			sat_q <= 1'b0;
		end else if (cmd.accept) begin
			sum_q <= sum_nxt;
			cnt_q <= cnt_nxt;
			if (!room) sat_q <= 1'b1;
			if (pixel < min_q) min_q <= pixel;
			if (pixel > max_q) max_q <= pixel;
		end
	end

	// divisor starts at count << 7 and halves each step; quotient < 256
	always_ff @(posedge clk) begin
		if (cmd.accept && cmd.last) begin
			rem_q <= sum_nxt;
			dvs_q <= SUM_W'({cnt_nxt, {(QUO_W-1){1'b0}}});
			quo_q <= '0;
		end else if (cmd.step) begin
			if (ge) rem_q <= rem_q - dvs_q;
			dvs_q <= dvs_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result <= {6'b0, sat_q, range_w <= thresh_q, range_w, quo_q};
		end
	end

endmodule

// ----- design/rmr_ctrl.sv -----
// ----------------------------------------------------------------------------
// Region mean and range test - controller
// Sequences intake, the divide steps and the hand-over to the result reg.
// ----------------------------------------------------------------------------
module rmr_ctrl import rmr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	input  logic     s_tlast,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	output rmr_cmd_t cmd
);

	rmr_state_t        state_q, state_nxt;
	logic [STEP_W-1:0] step_q;
	logic              out_free;

	assign out_free = !m_tvalid || m_tready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_ACCUM:  if (s_tvalid && s_tlast) state_nxt = ST_DIVIDE;
			ST_DIVIDE: if (step_q == '0) state_nxt = ST_DONE;
			ST_DONE:   if (out_free) state_nxt = ST_ACCUM;
			default:   state_nxt = ST_ACCUM;
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd        = '0;
		case (state_q)
			ST_ACCUM: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
				cmd.last   = s_tvalid && s_tlast;
			end
			ST_DIVIDE: begin
				cmd.step = 1'b1;
			end
			ST_DONE: begin
				cmd.finish = out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_ACCUM;
			step_q   <= STEP_LAST;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.last) step_q <= STEP_LAST;
			else if (cmd.step) step_q <= step_q - STEP_W'(1);
			if (cmd.finish) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

endmodule

// ----- design/region_mean_and_range_test.sv -----
// ----------------------------------------------------------------------------
// Region mean and range test - top level
// Per region mean, max-min range and similarity flag over a pixel stream.
// ----------------------------------------------------------------------------
//  channel   dir  tdata fields (lsb up)                          tlast
//  s_        in   pixel[7:0]                                     last_pixel
//  m_        out  mean_value[7:0] value_range[15:8]
//                 is_similar[16] overflow[17] zero[23:18]        -
//  cfg_      in   similarity_threshold[7:0] on cfg_we            -
//
// One pixel per cycle inside a region. After the closing pixel, intake
// stops for the 8 steps of the bit-serial divider and a load of the
// result register, longer if that register still holds an untaken
// result. Pixels of the next region are taken while a result waits.
// arst_n clears the statistics, threshold and handshake state at once.
// ----------------------------------------------------------------------------
`include "region_mean_and_range_test_macros.svh"

module region_mean_and_range_test import rmr_pkg::*; #(
	parameter int MAX_PIXELS = 262144
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // pixel
	input  logic                   s_tlast,   // last_pixel
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // mean_value, value_range, is_similar, overflow
	input  logic                   cfg_we,
	input  logic [PIX_W-1:0]       cfg_wdata
);

	rmr_cmd_t cmd;

	rmr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	rmr_datapath #(
		.MAX_PIXELS (MAX_PIXELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.pixel     (s_tdata[PIX_W-1:0]),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (m_tdata)
	);

	`RMR_ASSERT_IMP(a_no_intake_in_divide, cmd.step || cmd.finish, !s_tready, "intake during divide")
	`RMR_ASSERT_IMP(a_no_result_overwrite, cmd.finish, !m_tvalid || m_tready, "result overwritten")
	`RMR_ASSERT_NXT(a_result_shown, cmd.finish, m_tvalid, "result not presented")
	`RMR_ASSERT_NXT(a_divide_follows_last, cmd.last, cmd.step, "divider not started")

endmodule
